### rtl/sorted_key_interpolation_search_assert.svh
// Assertion macros shared by the checker of the sorted key interpolation search.
// No dependencies; included by the checker file.
`ifndef SORTED_KEY_INTERPOLATION_SEARCH_ASSERT_SVH
`define SORTED_KEY_INTERPOLATION_SEARCH_ASSERT_SVH

// ante and cons true in the same cycle
`define SKS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sksrch assertion failed");

// cons true in the cycle after ante
`define SKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sksrch assertion failed");

`endif

### rtl/sksrch_pkg.sv
// Types and constants of the sorted key interpolation search.
// No dependencies; used by every module of the block.
`default_nettype none

package sksrch_pkg;

  localparam int KEY_W   = 63;
  localparam int IDX_W   = 10;
  localparam int LAYER_W = 3;
  localparam int SIDX_W  = IDX_W + 2;   // signed bound, holds -1 .. 1024

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_WRITE   = 2'd0;
  localparam cmd_t CMD_SET_END = 2'd1;
  localparam cmd_t CMD_LOOKUP  = 2'd2;

  typedef struct packed {
    cmd_t               command;
    logic [LAYER_W-1:0] layer;
    logic [IDX_W-1:0]   slot;
    logic [KEY_W-1:0]   key;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOP,
    ST_RD_END,
    ST_WAIT_END,
    ST_TEST,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_PROBE,
    ST_RD_PROBE,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_START,
    RD_END,
    RD_PROBE
  } rd_sel_t;

  typedef struct packed {
    logic    accept;
    logic    wr_entry;
    logic    wr_end;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_ks;
    logic    cap_ke;
    logic    mul;
    logic    div_init;
    logic    div_step;
    logic    set_probe;
    logic    step_bounds;
    logic    hit_start;
    logic    hit_probe;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t command;
    logic layer_ok;
    logic slot_ok;
    logic empty;
    logic outside;
    logic single;
    logic ks_eq_key;
    logic bounds_eq;
    logic pk_eq;
    logic div_last;
    logic rsp_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/sksrch_ctrl.sv
// Sequencer of the interpolation search: handshake on the request side and datapath commands.
// Depends on sksrch_pkg.
`default_nettype none

module sksrch_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire sksrch_pkg::dp_stat_t stat,
  output sksrch_pkg::dp_cmd_t      cmd
);

  sksrch_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sksrch_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sksrch_pkg::ST_IDLE: begin
        if (req_valid && stat.command == sksrch_pkg::CMD_LOOKUP) begin
          state_next = stat.layer_ok ? sksrch_pkg::ST_LOOP : sksrch_pkg::ST_DONE;
        end
      end
      sksrch_pkg::ST_LOOP: begin
        state_next = stat.empty ? sksrch_pkg::ST_DONE : sksrch_pkg::ST_RD_END;
      end
      sksrch_pkg::ST_RD_END:   state_next = sksrch_pkg::ST_WAIT_END;
      sksrch_pkg::ST_WAIT_END: state_next = sksrch_pkg::ST_TEST;
      sksrch_pkg::ST_TEST: begin
        priority if (stat.outside || stat.single) begin
          state_next = sksrch_pkg::ST_DONE;
        end else if (stat.bounds_eq) begin
          state_next = sksrch_pkg::ST_RD_PROBE;
        end else begin
          state_next = sksrch_pkg::ST_MUL;
        end
      end
      sksrch_pkg::ST_MUL:      state_next = sksrch_pkg::ST_DIV_INIT;
      sksrch_pkg::ST_DIV_INIT: state_next = sksrch_pkg::ST_DIV;
      sksrch_pkg::ST_DIV: begin
        if (stat.div_last) begin
          state_next = sksrch_pkg::ST_PROBE;
        end
      end
      sksrch_pkg::ST_PROBE:    state_next = sksrch_pkg::ST_RD_PROBE;
      sksrch_pkg::ST_RD_PROBE: state_next = sksrch_pkg::ST_CMP;
      sksrch_pkg::ST_CMP: begin
        state_next = stat.pk_eq ? sksrch_pkg::ST_DONE : sksrch_pkg::ST_LOOP;
      end
      sksrch_pkg::ST_DONE: begin
        if (stat.rsp_free) begin
          state_next = sksrch_pkg::ST_IDLE;
        end
      end
      default: state_next = sksrch_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = sksrch_pkg::RD_START;
    req_stall = (state != sksrch_pkg::ST_IDLE);
    unique case (state)
      sksrch_pkg::ST_IDLE: begin
        cmd.accept   = req_valid;
        cmd.wr_entry = req_valid && stat.command == sksrch_pkg::CMD_WRITE
                       && stat.layer_ok && stat.slot_ok;
        cmd.wr_end   = req_valid && stat.command == sksrch_pkg::CMD_SET_END
                       && stat.layer_ok && stat.slot_ok;
      end
      sksrch_pkg::ST_LOOP: begin
        cmd.rd_en  = !stat.empty;
        cmd.rd_sel = sksrch_pkg::RD_START;
      end
      sksrch_pkg::ST_RD_END: begin
        cmd.cap_ks = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = sksrch_pkg::RD_END;
      end
      sksrch_pkg::ST_WAIT_END: cmd.cap_ke = 1'b1;
      sksrch_pkg::ST_TEST: begin
        cmd.hit_start = !stat.outside && stat.single && stat.ks_eq_key;
        cmd.set_probe = !stat.outside && !stat.single && stat.bounds_eq;
      end
      sksrch_pkg::ST_MUL:      cmd.mul = 1'b1;
      sksrch_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
      sksrch_pkg::ST_DIV:      cmd.div_step = 1'b1;
      sksrch_pkg::ST_PROBE:    cmd.set_probe = 1'b1;
      sksrch_pkg::ST_RD_PROBE: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = sksrch_pkg::RD_PROBE;
      end
      sksrch_pkg::ST_CMP: begin
        cmd.hit_probe   = stat.pk_eq;
        cmd.step_bounds = !stat.pk_eq;
      end
      sksrch_pkg::ST_DONE: cmd.emit = stat.rsp_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/sksrch_dp.sv
// Datapath: key memory, layer end registers, bounds, scaled divider and result register.
// Depends on sksrch_pkg.
`default_nettype none

module sksrch_dp #(
  parameter int NUM_LAYERS  = 8,
  parameter int LAYER_DEPTH = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sksrch_pkg::req_t    req,
  input  wire sksrch_pkg::dp_cmd_t cmd,
  output sksrch_pkg::dp_stat_t     stat,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output sksrch_pkg::rsp_t         rsp
);

  localparam int KW  = sksrch_pkg::KEY_W;
  localparam int IW  = sksrch_pkg::IDX_W;
  localparam int SW  = sksrch_pkg::SIDX_W;
  localparam int LW  = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam int AW  = (NUM_LAYERS * LAYER_DEPTH > 1) ? $clog2(NUM_LAYERS * LAYER_DEPTH) : 1;
  localparam int PW  = KW + IW;
  localparam int CW  = $clog2(IW + 1);

  logic [KW-1:0] mem [NUM_LAYERS * LAYER_DEPTH];
  logic [IW-1:0] layer_end [NUM_LAYERS];

  logic [KW-1:0]        key_r, ks, ke, m, rdata;
  logic [LW-1:0]        lay_r;
  logic signed [SW-1:0] st, en;
  logic [PW-1:0]        prod;
  logic [KW:0]          rem;
  logic [IW-1:0]        lo, q, probe, hit_idx;
  logic [CW-1:0]        cnt;
  logic                 hit;

  logic [LW-1:0] req_lay;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [IW-1:0] rd_idx, span;
  logic [KW:0]   r2;
  logic          ge;

  assign req_lay = LW'(req.layer);
  assign wr_addr = AW'(req_lay) * AW'(LAYER_DEPTH) + AW'(req.slot);

  always_comb begin
    unique case (cmd.rd_sel)
      sksrch_pkg::RD_START: rd_idx = IW'(st);
      sksrch_pkg::RD_END:   rd_idx = IW'(en);
      sksrch_pkg::RD_PROBE: rd_idx = probe;
      default:              rd_idx = probe;
    endcase
  end
  assign rd_addr = AW'(lay_r) * AW'(LAYER_DEPTH) + AW'(rd_idx);

  always_ff @(posedge clk) begin
    if (cmd.wr_entry) begin
      mem[wr_addr] <= req.key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LAYERS; i++) begin
        layer_end[i] <= '0;
      end
    end else if (cmd.wr_end) begin
      layer_end[req_lay] <= req.slot;
    end
  end

  // one restoring step; quotient fits IW bits because key - ks <= ke - ks
  assign r2   = {rem[KW-1:0], lo[IW-1]};
  assign ge   = (r2 >= {1'b0, m});
  assign span = IW'(en - st);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r <= req.key;
      lay_r <= req_lay;
      st    <= '0;
      en    <= $signed({2'b00, layer_end[req_lay]});
    end
    if (cmd.cap_ks) ks <= rdata;
    if (cmd.cap_ke) ke <= rdata;
    if (cmd.mul) begin
      prod <= PW'(span) * PW'(key_r - ks);
      m    <= ke - ks;
    end
    if (cmd.div_init) begin
      rem <= {1'b0, prod[PW-1:IW]};
      lo  <= prod[IW-1:0];
      q   <= '0;
      cnt <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? (r2 - {1'b0, m}) : r2;
      lo  <= {lo[IW-2:0], 1'b0};
      q   <= {q[IW-2:0], ge};
      cnt <= cnt + CW'(1);
    end
    if (cmd.set_probe) begin
      probe <= stat.bounds_eq ? IW'(st) : IW'(st) + q;
    end
    if (cmd.step_bounds) begin
      if (rdata < key_r) begin
        st <= $signed({2'b00, probe}) + SW'(1);
      end else begin
        en <= $signed({2'b00, probe}) - SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.accept) begin
      hit <= 1'b0;
    end else if (cmd.hit_start || cmd.hit_probe) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hit_start) begin
      hit_idx <= IW'(st);
    end else if (cmd.hit_probe) begin
      hit_idx <= probe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.found       <= hit;
      rsp.match_index <= hit ? hit_idx : '0;
    end
  end

  always_comb begin
    stat.command   = req.command;
    stat.layer_ok  = 32'(req.layer) < NUM_LAYERS;
    stat.slot_ok   = 32'(req.slot) < LAYER_DEPTH;
    stat.empty     = st > en;
    stat.outside   = (key_r < ks) || (key_r > ke);
    stat.single    = st == en;
    stat.ks_eq_key = ks == key_r;
    stat.bounds_eq = ks == ke;
    stat.pk_eq     = rdata == key_r;
    stat.div_last  = cnt == CW'(IW - 1);
    stat.rsp_free  = !rsp_valid || !rsp_stall;
  end

endmodule

`default_nettype wire

### rtl/sorted_key_interpolation_search.sv
// Top level of the sorted key interpolation search: sequencer plus datapath.
// Depends on sksrch_pkg, sksrch_ctrl and sksrch_dp.
//
// Use: one request channel (req_valid/req_stall/req) carries a command word:
// write a key into a layer's table, set a layer's last index, or look up a key.
// Writes and sets take effect in the accepting cycle and give no response.
// A lookup gives one response word (rsp_valid/rsp_stall/rsp): found and the
// matching index, index zero when not found.
// Throughput: a write or set is taken every cycle while no lookup is busy. A lookup
// holds req_stall high until its response is registered: the bounds are read and
// tested, then each probe that divides runs a multiply, a restoring divider, a
// probe read and a compare, and a probe with equal bound keys only the read and
// compare; the single memory read port fetches start, end and probe keys one after
// the other. A lookup of an unknown layer gives its response without a search.
// Reset clears the sequencer, the response valid flag and every layer's last
// index; table contents stay undefined until written.
// A stalled response is held; the block stays busy only until the next
// response would have to overwrite it.
`default_nettype none

module sorted_key_interpolation_search #(
  parameter int NUM_LAYERS  = 8,
  parameter int LAYER_DEPTH = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire sksrch_pkg::req_t req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output sksrch_pkg::rsp_t      rsp
);

  sksrch_pkg::dp_cmd_t  cmd;
  sksrch_pkg::dp_stat_t stat;

  // control: handshake and search sequence
  sksrch_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage, bounds, divider and response register
  sksrch_dp #(
    .NUM_LAYERS  (NUM_LAYERS),
    .LAYER_DEPTH (LAYER_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

### rtl/sksrch_checker.sv
// Port-level checks of the sorted key interpolation search, bound to the top level.
// Depends on sksrch_pkg and sorted_key_interpolation_search_assert.svh.
`default_nettype none

`include "sorted_key_interpolation_search_assert.svh"

module sksrch_checker #(
  parameter int LAYER_DEPTH = 1024
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             req_valid,
  input wire logic             req_stall,
  input wire sksrch_pkg::req_t req,
  input wire logic             rsp_valid,
  input wire logic             rsp_stall,
  input wire sksrch_pkg::rsp_t rsp
);

  `SKS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `SKS_ASSERT_NOW(a_miss_zero, clk, rst, rsp_valid && !rsp.found, rsp.match_index == '0)
  `SKS_ASSERT_NEXT(a_lookup_busy, clk, rst,
    req_valid && !req_stall && req.command == sksrch_pkg::CMD_LOOKUP, req_stall)
  `SKS_ASSERT_NOW(a_idx_range, clk, rst, rsp_valid && rsp.found,
    32'(rsp.match_index) < LAYER_DEPTH)

endmodule

bind sorted_key_interpolation_search sksrch_checker #(.LAYER_DEPTH(LAYER_DEPTH)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the sorted key interpolation search.
// Depends on sksrch_pkg and the sorted_key_interpolation_search top level.
`timescale 1ns / 100ps

module tb_top;

  localparam int NL          = 8;
  localparam int LD          = 1024;
  localparam int SMALL_FILL  = 32;        // entries preloaded in layers 0..6
  localparam int RAND_WORDS  = 334;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int KW          = sksrch_pkg::KEY_W;
  localparam int IW          = sksrch_pkg::IDX_W;
  localparam int LW          = sksrch_pkg::LAYER_W;
  localparam sksrch_pkg::cmd_t CMD_UNKNOWN = 2'd3;

  typedef struct {
    sksrch_pkg::req_t w;
    bit               typed;    // expected result typed in below
    sksrch_pkg::rsp_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  sksrch_pkg::req_t req = '0;
  logic req_stall;
  logic rsp_valid;
  sksrch_pkg::rsp_t rsp;

  // shadow of the block's tables
  logic [KW-1:0] key_mem [NL][LD];
  int            last_idx [NL];
  int            fill_len [NL];     // entries 0..fill_len-1 have been written

  sksrch_pkg::rsp_t lookup_q [$];
  row_t             rows [$];
  int               errors = 0;
  int               burst_left = 0;
  int unsigned      cycles = 0;
  logic             acc_q = 1'b0;

  always #5 clk = ~clk;

  sorted_key_interpolation_search #(.NUM_LAYERS(NL), .LAYER_DEPTH(LD)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // word taken at this edge; read back at the following falling edge
  always @(posedge clk) begin
    acc_q <= req_valid && !req_stall;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Exact interpolation search over the shadow table.
  function automatic sksrch_pkg::rsp_t search_key(int l, logic [KW-1:0] k);
    int s;
    int e;
    int p;
    logic [127:0] num;
    logic [KW-1:0] ks;
    logic [KW-1:0] ke;
    sksrch_pkg::rsp_t r;
    r = '0;
    s = 0;
    e = last_idx[l];
    while (s <= e && k >= key_mem[l][s] && k <= key_mem[l][e]) begin
      ks = key_mem[l][s];
      ke = key_mem[l][e];
      if (s == e) begin
        if (ks == k) begin
          r.found = 1'b1;
          r.match_index = IW'(s);
        end
        return r;
      end
      if (ke == ks) p = s;
      else begin
        num = 128'(e - s) * 128'(k - ks);
        p = s + int'(num / 128'(ke - ks));
      end
      if (key_mem[l][p] == k) begin
        r.found = 1'b1;
        r.match_index = IW'(p);
        return r;
      end
      if (key_mem[l][p] < k) s = p + 1;
      else e = p - 1;
    end
    return r;
  endfunction

  function automatic sksrch_pkg::req_t mk(sksrch_pkg::cmd_t c, int l, int s, logic [KW-1:0] k);
    sksrch_pkg::req_t w;
    w.command = c;
    w.layer   = LW'(l);
    w.slot    = IW'(s);
    w.key     = k;
    return w;
  endfunction

  function automatic sksrch_pkg::rsp_t hit(bit f, int i);
    sksrch_pkg::rsp_t r;
    r.found = f;
    r.match_index = IW'(i);
    return r;
  endfunction

  // Present one word, hold it until taken, then update the shadow state.
  task automatic send_word(sksrch_pkg::req_t w, bit typed, sksrch_pkg::rsp_t want);
    int gap;
    req <= w;
    req_valid <= 1'b1;
    do @(negedge clk); while (!acc_q);
    case (w.command)
      sksrch_pkg::CMD_WRITE: begin
        key_mem[w.layer][w.slot] = w.key;
        if (int'(w.slot) == fill_len[w.layer]) fill_len[w.layer]++;
      end
      sksrch_pkg::CMD_SET_END: last_idx[w.layer] = int'(w.slot);
      sksrch_pkg::CMD_LOOKUP:
        lookup_q.push_back(typed ? want : search_key(int'(w.layer), w.key));
      default: ;
    endcase
    // bursts with idle gaps between them
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // receiver stall pattern: quiet, light or heavy stretches
  int stall_mode = 0;
  always @(negedge clk) begin
    if (cycles % 300 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      default: rsp_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // response check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (lookup_q.size() == 0) report_mismatch("unexpected word", 1, 0);
      else begin
        if (rsp.found !== lookup_q[0].found)
          report_mismatch("found", int'(rsp.found), int'(lookup_q[0].found));
        if (rsp.match_index !== lookup_q[0].match_index)
          report_mismatch("match_index", int'(rsp.match_index),
                          int'(lookup_q[0].match_index));
        void'(lookup_q.pop_front());
      end
    end
  end

  initial begin
    logic [KW-1:0] k;
    logic [KW-1:0] kmax;
    int l;
    int s;
    int r;
    sksrch_pkg::rsp_t none;
    none = '0;
    kmax = '1;
    for (int i = 0; i < NL; i++) begin
      last_idx[i] = 0;
      fill_len[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // preload: layer 0 evenly spaced, layer 1 all equal, layer 7 full and spanning
    // the whole key range, the rest sorted random
    for (int i = 0; i < SMALL_FILL; i++) begin
      send_word(mk(sksrch_pkg::CMD_WRITE, 0, i, KW'(i * 4096 + 7)), 0, none);
      send_word(mk(sksrch_pkg::CMD_WRITE, 1, i, KW'(42)), 0, none);
    end
    for (int j = 2; j < 7; j++) begin
      k = KW'($urandom_range(0, 1000));
      for (int i = 0; i < SMALL_FILL; i++) begin
        k = k + KW'($urandom_range(1, 1 << 20)) + (KW'($urandom) << 30);
        send_word(mk(sksrch_pkg::CMD_WRITE, j, i, k), 0, none);
      end
    end
    for (int i = 0; i < LD; i++)
      send_word(mk(sksrch_pkg::CMD_WRITE, 7, i, (i == LD - 1) ? kmax : (KW'(i) << 53)),
                0, none);

    // directed words
    rows.push_back('{mk(CMD_UNKNOWN, 5, 1023, kmax), 0, none});                 // unknown command
    rows.push_back('{mk(sksrch_pkg::CMD_LOOKUP, 0, 0, KW'(7)), 1, hit(1, 0)}); // single entry hit
    rows.push_back('{mk(sksrch_pkg::CMD_LOOKUP, 0, 0, KW'(0)), 1, none});      // below range
    rows.push_back('{mk(sksrch_pkg::CMD_LOOKUP, 0, 0, kmax), 1, none});        // above range
    rows.push_back('{mk(sksrch_pkg::CMD_SET_END, 0, 31, '0), 0, none});
    rows.push_back('{mk(sksrch_pkg::CMD_LOOKUP, 0, 0, KW'(7)), 1, hit(1, 0)});
    rows.push_back('{mk(sksrch_pkg::CMD_LOOKUP, 0, 0, KW'(31 * 4096 + 7)), 1, hit(1, 31)});
    rows.push_back('{mk(sksrch_pkg::CMD_LOOKUP, 0, 0, KW'(10 * 4096 + 7)), 0, none});
    rows.push_back('{mk(sksrch_pkg::CMD_LOOKUP, 0, 0, KW'(10 * 4096 + 8)), 0, none});
    rows.push_back('{mk(sksrch_pkg::CMD_SET_END, 1, 31, '0), 0, none});       // equal bound keys
    rows.push_back('{mk(sksrch_pkg::CMD_LOOKUP, 1, 0, KW'(42)), 1, hit(1, 0)});
    rows.push_back('{mk(sksrch_pkg::CMD_LOOKUP, 1, 0, KW'(41)), 1, none});
    rows.push_back('{mk(sksrch_pkg::CMD_SET_END, 7, 1023, '0), 0, none});
    rows.push_back('{mk(sksrch_pkg::CMD_LOOKUP, 7, 0, kmax), 1, hit(1, 1023)});
    rows.push_back('{mk(sksrch_pkg::CMD_LOOKUP, 7, 0, KW'(0)), 1, hit(1, 0)});
    rows.push_back('{mk(sksrch_pkg::CMD_LOOKUP, 7, 0, KW'(500) << 53), 0, none});
    rows.push_back('{mk(sksrch_pkg::CMD_LOOKUP, 7, 0, (KW'(500) << 53) + 1), 0, none});
    rows.push_back('{mk(sksrch_pkg::CMD_LOOKUP, 7, 1023, kmax - 1), 0, none});
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);

    // random words: mostly lookups of stored keys, plus table churn
    for (int n = 0; n < RAND_WORDS; n++) begin
      r = $urandom_range(0, 99);
      l = $urandom_range(0, 7);
      if (r < 30) begin
        if (l == 7) l = $urandom_range(0, 6);
        s = $urandom_range(0, (fill_len[l] < LD) ? fill_len[l] : LD - 1);
        if ($urandom_range(0, 1) == 0) k = KW'({$urandom, $urandom});
        else k = key_mem[l][(s > 0) ? s - 1 : 0] + KW'($urandom_range(0, 3));
        send_word(mk(sksrch_pkg::CMD_WRITE, l, s, k), 0, none);
      end else if (r < 42) begin
        s = (l == 7) ? $urandom_range(0, LD - 1) : $urandom_range(0, fill_len[l] - 1);
        send_word(mk(sksrch_pkg::CMD_SET_END, l, s, KW'({$urandom, $urandom})), 0, none);
      end else if (r < 47) begin
        send_word(mk(CMD_UNKNOWN, l, $urandom_range(0, LD - 1), KW'({$urandom, $urandom})),
                  0, none);
      end else begin
        r = $urandom_range(0, 99);
        k = key_mem[l][$urandom_range(0, last_idx[l])];
        if (r < 10) k = k + 1;
        else if (r < 18) k = k - 1;
        else if (r < 33) k = KW'({$urandom, $urandom});
        else if (r < 38) k = '0;
        else if (r < 43) k = kmax;
        send_word(mk(sksrch_pkg::CMD_LOOKUP, l, $urandom_range(0, LD - 1), k), 0, none);
      end
    end
    req_valid <= 1'b0;

    while (lookup_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0 && lookup_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
